[design/gmap_pkg.sv]
// gmap_pkg: shared constants, types and the exp2 root table function
// for the gain map apply pipeline; used by every gmap module and the top level
`timescale 1ns / 1ps

package gmap_pkg;

    localparam int LOG_STAGES = 16;
    localparam int EXP_STAGES = 16;

    // pipeline depth: log2, gamma mult, exp2, pick, two lerp, weight mult,
    // exp2, two output stages
    localparam int PIPE_DEPTH = LOG_STAGES + 2 + EXP_STAGES + 4 + EXP_STAGES + 2;
    localparam int ZG_DELAY   = LOG_STAGES + 2 + EXP_STAGES;
    localparam int S_DELAY    = PIPE_DEPTH - 2;
    localparam int NA_DELAY   = EXP_STAGES;
    localparam int NB_DELAY   = EXP_STAGES + 1;

    localparam logic [47:0] GAIN_MIN_RST    = 48'h0000_0000_0000;
    localparam logic [47:0] GAIN_MAX_RST    = 48'h2000_2000_2000;
    localparam logic [47:0] GAMMA_RECIP_RST = 48'h1000_1000_1000;
    localparam logic [47:0] OFFSET_RST      = 48'h0200_0200_0200;
    localparam logic [15:0] BASE_HR_RST     = 16'h0000;
    localparam logic [15:0] ALT_HR_RST      = 16'h2000;
    localparam logic [15:0] DISP_HR_RST     = 16'h2000;

    typedef enum logic [2:0] {
        CFG_GAIN_MIN,
        CFG_GAIN_MAX,
        CFG_GAMMA_RECIP,
        CFG_BASE_OFFSET,
        CFG_ALT_OFFSET,
        CFG_BASE_HR,
        CFG_ALT_HR,
        CFG_DISP_HR
    } t_cfg_index;

    typedef enum logic [1:0] {
        WD_IDLE,
        WD_LOAD,
        WD_RUN
    } t_wdiv_state;

    typedef struct packed {
        logic [15:0] gmin;
        logic [15:0] gmax;
        logic [15:0] grecip;
        logic [15:0] boff;
        logic [15:0] aoff;
    } t_chan_cfg;

    // q.30 root of 2^(2^-k), each step floored
    function automatic logic [31:0] gmap_root(input int k);
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        int i;
        int j;
        r = 64'd1 << 31;
        for (i = 1; i <= k; i++) begin
            v   = r << 30;
            res = 64'd0;
            bt  = 64'd1 << 62;
            for (j = 0; j < 32; j++) begin
                if (v >= res + bt) begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            r = res;
        end
        return r[31:0];
    endfunction

endpackage

[design/gmap_log2.sv]
// gmap_log2: pipelined log2 of a q0.16 gain sample, a normalising stage then one squaring per stage
// depends on gmap_pkg
`timescale 1ns / 1ps

module gmap_log2 import gmap_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_gain,
    output logic [20:0] o_log2
);

    logic [30:0] r_x    [LOG_STAGES+1];
    logic [15:0] r_frac [LOG_STAGES+1];
    logic [3:0]  r_msb  [LOG_STAGES+1];
    logic [30:0] n_x    [LOG_STAGES+1];
    logic [15:0] n_frac [LOG_STAGES+1];
    logic [3:0]  n_msb  [LOG_STAGES+1];

    always_comb begin
        logic [61:0] sq;
        logic [31:0] t;
        n_msb[0] = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (i_gain[i]) begin
                n_msb[0] = 4'(i);
            end
        end
        n_x[0]    = 31'(i_gain) << (5'd30 - {1'b0, n_msb[0]});
        n_frac[0] = 16'd0;
        for (int j = 1; j <= LOG_STAGES; j++) begin
            sq        = 62'(r_x[j-1]) * 62'(r_x[j-1]);
            t         = sq[61:30];
            n_x[j]    = t[31] ? t[31:1] : t[30:0];
            n_frac[j] = {r_frac[j-1][14:0], t[31]};
            n_msb[j]  = r_msb[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j <= LOG_STAGES; j++) begin
                r_x[j]    <= n_x[j];
                r_frac[j] <= n_frac[j];
                r_msb[j]  <= n_msb[j];
            end
        end
    end

    // integer part msb - 16 is always negative: sign bit then msb
    assign o_log2 = {1'b1, r_msb[LOG_STAGES], r_frac[LOG_STAGES]};

endmodule

[design/gmap_exp2.sv]
// gmap_exp2: pipelined q.30 mantissa of 2^(f/65536), one root multiply per stage
// depends on gmap_pkg (root table function)
`timescale 1ns / 1ps

module gmap_exp2 import gmap_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_frac,
    output logic [30:0] o_mant
);

    logic [31:0] roots [EXP_STAGES];
    logic [30:0] r_acc [EXP_STAGES];
    logic [15:0] r_f   [EXP_STAGES];
    logic [30:0] n_acc [EXP_STAGES];
    logic [15:0] n_f   [EXP_STAGES];

    for (genvar k = 0; k < EXP_STAGES; k++) begin : g_root
        localparam logic [31:0] RK = gmap_root(k + 1);
        assign roots[k] = RK;
    end

    always_comb begin
        logic [30:0] acc_in;
        logic [15:0] f_in;
        logic [62:0] prod;
        for (int j = 0; j < EXP_STAGES; j++) begin
            acc_in   = (j == 0) ? 31'h4000_0000 : r_acc[(j == 0) ? 0 : j - 1];
            f_in     = (j == 0) ? i_frac : r_f[(j == 0) ? 0 : j - 1];
            prod     = 63'(acc_in) * 63'(roots[j]);
            n_acc[j] = f_in[EXP_STAGES-1-j] ? prod[60:30] : acc_in;
            n_f[j]   = f_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < EXP_STAGES; j++) begin
                r_acc[j] <= n_acc[j];
                r_f[j]   <= n_f[j];
            end
        end
    end

    assign o_mant = r_acc[EXP_STAGES-1];

endmodule

[design/gmap_wdiv.sv]
// gmap_wdiv: serial restoring divider for the headroom weight, one bit a cycle
// depends on gmap_pkg (state type)
`timescale 1ns / 1ps

module gmap_wdiv import gmap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_base_hr,
    input  logic signed [15:0] i_alt_hr,
    input  logic signed [15:0] i_disp_hr,
    output logic               o_busy,
    output logic signed [17:0] o_weight
);

    t_wdiv_state r_state, n_state;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_den, n_den;
    logic [15:0] r_q, n_q;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic [17:0] r_weight, n_weight;

    logic signed [16:0] num;
    logic signed [16:0] den;

    assign num = $signed({i_disp_hr[15], i_disp_hr}) - $signed({i_base_hr[15], i_base_hr});
    assign den = $signed({i_alt_hr[15], i_alt_hr}) - $signed({i_base_hr[15], i_base_hr});

    always_comb begin
        logic signed [16:0] nm;
        logic signed [16:0] dm;
        logic [17:0]        rem2;
        logic               qbit;
        n_state  = r_state;
        n_rem    = r_rem;
        n_den    = r_den;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_weight = r_weight;
        nm       = den[16] ? -num : num;
        dm       = den[16] ? -den : den;
        rem2     = {r_rem, 1'b0};
        qbit     = rem2 >= {1'b0, r_den};
        unique case (r_state)
            WD_IDLE: begin
                n_state = WD_IDLE;
            end
            WD_LOAD: begin
                n_neg = den[16];
                n_rem = nm[16:0];
                n_den = dm[16:0];
                n_q   = 16'd0;
                n_cnt = 4'd0;
                if (den == 17'sd0 || nm <= 17'sd0) begin
                    n_weight = 18'd0;
                    n_state  = WD_IDLE;
                end else if (nm >= dm) begin
                    n_weight = den[16] ? 18'h3_0000 : 18'h1_0000;
                    n_state  = WD_IDLE;
                end else begin
                    n_state = WD_RUN;
                end
            end
            WD_RUN: begin
                n_rem = qbit ? 17'(rem2 - {1'b0, r_den}) : rem2[16:0];
                n_q   = {r_q[14:0], qbit};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_weight = r_neg ? 18'd0 - {2'b00, n_q} : {2'b00, n_q};
                    n_state  = WD_IDLE;
                end
            end
            default: begin
                n_state = WD_LOAD;
            end
        endcase
        if (i_start) begin
            n_state = WD_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WD_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_q      <= n_q;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_weight <= n_weight;
    end

    assign o_busy   = r_state != WD_IDLE;
    assign o_weight = $signed(r_weight);

endmodule

[design/gmap_chan.sv]
// gmap_chan: per-channel gain map pipeline, log2, power, lerp, exp2 and scale
// depends on gmap_pkg, gmap_log2, gmap_exp2
`timescale 1ns / 1ps

module gmap_chan import gmap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_chan_cfg          i_cfg,
    input  logic signed [17:0] i_weight,
    input  logic [15:0]        i_base,
    input  logic [15:0]        i_gain,
    output logic signed [31:0] o_out
);

    logic [20:0] lg;
    logic [30:0] mant_a;
    logic [30:0] mant_b;

    logic [17:0] r_s_dly  [S_DELAY];
    logic        r_zg_dly [ZG_DELAY];
    logic [9:0]  r_n_dly  [NA_DELAY];
    logic [4:0]  r_n2_dly [NB_DELAY];

    logic [25:0]        r_y;
    logic [16:0]        r_p, n_p;
    logic signed [33:0] r_pmin, r_pmax;
    logic signed [33:0] r_lg2;
    logic [20:0]        r_e;
    logic signed [49:0] r_vprod;
    logic signed [31:0] r_out, n_out;

    logic [17:0]        n_s;
    logic signed [37:0] y_prod;
    logic [16:0]        p_inv;
    logic signed [33:0] pmin_prod, pmax_prod;
    logic signed [51:0] e_prod;
    logic signed [49:0] v_prod;

    gmap_log2 u_log2 (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_gain (i_gain),
        .o_log2 (lg)
    );

    gmap_exp2 u_exp_pow (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_frac (r_y[15:0]),
        .o_mant (mant_a)
    );

    gmap_exp2 u_exp_gain (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_frac (r_e[15:0]),
        .o_mant (mant_b)
    );

    assign n_s       = {2'b00, i_base} + {{2{i_cfg.boff[15]}}, i_cfg.boff};
    assign y_prod    = $signed(lg) * $signed({1'b0, i_cfg.grecip});
    assign p_inv     = 17'(17'h1_0000 - r_p);
    assign pmin_prod = $signed(i_cfg.gmin) * $signed({1'b0, p_inv});
    assign pmax_prod = $signed(i_cfg.gmax) * $signed({1'b0, r_p});
    assign e_prod    = r_lg2 * i_weight;
    assign v_prod    = $signed(r_s_dly[S_DELAY-1]) * $signed({1'b0, mant_b});

    // gain power pick
    always_comb begin
        logic signed [9:0]  pn;
        logic signed [10:0] sh;
        pn = $signed(r_n_dly[NA_DELAY-1]);
        sh = 11'sd14 - {pn[9], pn};
        priority if (i_cfg.grecip == 16'd0) begin
            n_p = 17'h1_0000;
        end else if (r_zg_dly[ZG_DELAY-1]) begin
            n_p = 17'd0;
        end else if (pn < -10'sd17) begin
            n_p = 17'd0;
        end else begin
            n_p = 17'(mant_a >> sh[4:0]);
        end
    end

    // scale, offset and saturate
    always_comb begin
        logic signed [4:0]  n2;
        logic signed [6:0]  sh;
        logic signed [49:0] v_sh;
        logic signed [50:0] v_sub;
        n2    = $signed(r_n2_dly[NB_DELAY-1]);
        sh    = 7'sd29 - {{2{n2[4]}}, n2};
        v_sh  = r_vprod >>> sh[5:0];
        v_sub = {v_sh[49], v_sh} - $signed({{34{i_cfg.aoff[15]}}, i_cfg.aoff, 1'b0});
        priority if (v_sub > 51'sd2147483647) begin
            n_out = 32'sh7fff_ffff;
        end else if (v_sub < -51'sd2147483648) begin
            n_out = 32'sh8000_0000;
        end else begin
            n_out = v_sub[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_dly[0]  <= n_s;
            r_zg_dly[0] <= i_gain == 16'd0;
            r_n_dly[0]  <= r_y[25:16];
            r_n2_dly[0] <= r_e[20:16];
            for (int i = 1; i < S_DELAY; i++) begin
                r_s_dly[i] <= r_s_dly[i-1];
            end
            for (int i = 1; i < ZG_DELAY; i++) begin
                r_zg_dly[i] <= r_zg_dly[i-1];
            end
            for (int i = 1; i < NA_DELAY; i++) begin
                r_n_dly[i] <= r_n_dly[i-1];
            end
            for (int i = 1; i < NB_DELAY; i++) begin
                r_n2_dly[i] <= r_n2_dly[i-1];
            end
            r_y     <= y_prod[37:12];
            r_p     <= n_p;
            r_pmin  <= pmin_prod;
            r_pmax  <= pmax_prod;
            r_lg2   <= r_pmin + r_pmax;
            r_e     <= e_prod[48:28];
            r_vprod <= v_prod;
            r_out   <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

[design/gain_map_apply_pixel.sv]
// gain_map_apply_pixel: top level, configuration registers, weight divider,
// three channel pipelines; depends on gmap_pkg, gmap_wdiv, gmap_chan
`timescale 1ns / 1ps

// Applies a gain map to one linear RGB pixel per cycle when not stalled. A
// request passes a 56-stage pipeline per channel (two 16-stage exp2 chains
// and a 17-stage log2 chain set the depth). A stall on the output, while a
// result waits there, holds the whole pipeline. The headroom weight comes
// from a serial divider that runs after reset and after every headroom
// register write; the input is stalled while it runs. Configuration writes
// are always ready.

module gain_map_apply_pixel import gmap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_base_red,
    input  logic [15:0]        i_base_green,
    input  logic [15:0]        i_base_blue,
    input  logic [15:0]        i_gain_red,
    input  logic [15:0]        i_gain_green,
    input  logic [15:0]        i_gain_blue,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_red,
    output logic signed [31:0] o_out_green,
    output logic signed [31:0] o_out_blue,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);

    logic [47:0] r_gain_min;
    logic [47:0] r_gain_max;
    logic [47:0] r_gamma_recip;
    logic [47:0] r_base_offset;
    logic [47:0] r_alt_offset;
    logic [15:0] r_base_hr;
    logic [15:0] r_alt_hr;
    logic [15:0] r_disp_hr;

    logic r_valid [PIPE_DEPTH];

    logic               en;
    logic               wd_start;
    logic               wd_busy;
    logic signed [17:0] weight;
    t_chan_cfg          chan_cfg [3];
    logic [15:0]        base [3];
    logic [15:0]        gain [3];
    logic signed [31:0] pix  [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_min    <= GAIN_MIN_RST;
            r_gain_max    <= GAIN_MAX_RST;
            r_gamma_recip <= GAMMA_RECIP_RST;
            r_base_offset <= OFFSET_RST;
            r_alt_offset  <= OFFSET_RST;
            r_base_hr     <= BASE_HR_RST;
            r_alt_hr      <= ALT_HR_RST;
            r_disp_hr     <= DISP_HR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN_MIN:    r_gain_min    <= i_cfg_data;
                CFG_GAIN_MAX:    r_gain_max    <= i_cfg_data;
                CFG_GAMMA_RECIP: r_gamma_recip <= i_cfg_data;
                CFG_BASE_OFFSET: r_base_offset <= i_cfg_data;
                CFG_ALT_OFFSET:  r_alt_offset  <= i_cfg_data;
                CFG_BASE_HR:     r_base_hr     <= i_cfg_data[15:0];
                CFG_ALT_HR:      r_alt_hr      <= i_cfg_data[15:0];
                CFG_DISP_HR:     r_disp_hr     <= i_cfg_data[15:0];
            endcase
        end
    end

    assign wd_start = i_cfg_valid && (i_cfg_index == CFG_BASE_HR ||
                      i_cfg_index == CFG_ALT_HR || i_cfg_index == CFG_DISP_HR);

    gmap_wdiv u_wdiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (wd_start),
        .i_base_hr ($signed(r_base_hr)),
        .i_alt_hr  ($signed(r_alt_hr)),
        .i_disp_hr ($signed(r_disp_hr)),
        .o_busy    (wd_busy),
        .o_weight  (weight)
    );

    assign en      = !(r_valid[PIPE_DEPTH-1] && i_stall);
    assign o_stall = !en || wd_busy;
    assign o_valid = r_valid[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (en) begin
            r_valid[0] <= i_valid && !wd_busy;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                r_valid[i] <= r_valid[i-1];
            end
        end
    end

    assign base[0] = i_base_red;
    assign base[1] = i_base_green;
    assign base[2] = i_base_blue;
    assign gain[0] = i_gain_red;
    assign gain[1] = i_gain_green;
    assign gain[2] = i_gain_blue;

    for (genvar c = 0; c < 3; c++) begin : g_chan
        assign chan_cfg[c].gmin   = r_gain_min[16*c +: 16];
        assign chan_cfg[c].gmax   = r_gain_max[16*c +: 16];
        assign chan_cfg[c].grecip = r_gamma_recip[16*c +: 16];
        assign chan_cfg[c].boff   = r_base_offset[16*c +: 16];
        assign chan_cfg[c].aoff   = r_alt_offset[16*c +: 16];

        gmap_chan u_chan (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_cfg    (chan_cfg[c]),
            .i_weight (weight),
            .i_base   (base[c]),
            .i_gain   (gain[c]),
            .o_out    (pix[c])
        );
    end

    assign o_out_red   = pix[0];
    assign o_out_green = pix[1];
    assign o_out_blue  = pix[2];

endmodule
